### hw/rtl/tkls_pkg.sv
// package for the streaming k-th largest selector
// shared widths and default sizes, no dependencies
package tkls_pkg;

  localparam int DATA_W       = 32;
  localparam int RANK_W       = 7;
  localparam int DEF_MAX_RANK = 64;
  localparam int CFG_AW       = 2;
  localparam int CFG_DW       = 32;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [RANK_W-1:0]        rank_t;

endpackage

### hw/rtl/tkls_store.sv
// kept value store: one write port, one registered read port
// depends on tkls_pkg
module tkls_store #(
  parameter int DEPTH = tkls_pkg::DEF_MAX_RANK,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  tkls_pkg::sample_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output tkls_pkg::sample_t rd_data
);
  import tkls_pkg::*;

  sample_t mem [DEPTH];
  sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/tkls_ctrl.sv
// insertion sequencer with one shared signed compare, plus the result register
// depends on tkls_pkg and tkls_store
module tkls_ctrl #(
  parameter int MAX_RANK = tkls_pkg::DEF_MAX_RANK,
  parameter int KW       = 7,
  parameter int AW       = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [KW-1:0]     eff_k,
  input  logic              in_valid,
  output logic              in_stall,
  input  tkls_pkg::sample_t in_sample_value,
  input  logic              in_last_of_set,
  output logic              out_valid,
  input  logic              out_stall,
  output tkls_pkg::sample_t out_kth_value,
  output logic              out_short_set
);
  import tkls_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [KW-1:0] pos_r, pos_nxt;
  logic [KW-1:0] n_r, n_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] kept_count_r, kept_count_nxt;
  sample_t       v_r, v_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;
  sample_t       out_kth_value_r, out_kth_value_nxt;
  logic          out_short_set_r, out_short_set_nxt;

  logic          wr_en;
  logic [KW-1:0] wr_pos;
  sample_t       wr_data;
  logic [KW-1:0] rd_pos;
  sample_t       rd_data;
  logic [KW-1:0] pos_dec;
  logic [KW-1:0] n_dec;
  logic          rd_less;
  logic          accept;
  logic          slot_free;

  assign pos_dec   = pos_r - 1'b1;
  assign n_dec     = n_r - 1'b1;
  assign rd_less   = rd_data < v_r;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  tkls_store #(
    .DEPTH(MAX_RANK),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_pos[AW-1:0]),
    .wr_data(wr_data),
    .rd_addr(rd_pos[AW-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt         = state_r;
    pos_nxt           = pos_r;
    n_nxt             = n_r;
    k_nxt             = k_r;
    kept_count_nxt    = kept_count_r;
    v_nxt             = v_r;
    last_nxt          = last_r;
    out_valid_nxt     = out_valid_r;
    out_kth_value_nxt = out_kth_value_r;
    out_short_set_nxt = out_short_set_r;
    wr_en             = 1'b0;
    wr_pos            = pos_r;
    wr_data           = v_r;
    rd_pos            = pos_dec;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          v_nxt    = in_sample_value;
          last_nxt = in_last_of_set;
          k_nxt    = eff_k;
          n_nxt    = (kept_count_r > eff_k) ? eff_k : kept_count_r;
          pos_nxt  = n_nxt;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rd_less) begin
          wr_en     = (pos_r < k_r);
          wr_data   = rd_data;
          pos_nxt   = pos_dec;
          state_nxt = ST_SCAN;
        end else begin
          wr_en     = (pos_r < k_r);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (n_r < k_r) begin
          n_nxt = n_r + 1'b1;
        end
        // read of the smallest kept value, ready for the result load
        rd_pos         = n_nxt - 1'b1;
        kept_count_nxt = n_nxt;
        state_nxt      = last_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        rd_pos = n_dec;
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_kth_value_nxt = rd_data;
          out_short_set_nxt = (n_r < k_r);
          kept_count_nxt    = '0;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      kept_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kept_count_r <= kept_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r           <= pos_nxt;
    n_r             <= n_nxt;
    k_r             <= k_nxt;
    v_r             <= v_nxt;
    last_r          <= last_nxt;
    out_kth_value_r <= out_kth_value_nxt;
    out_short_set_r <= out_short_set_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kth_value = out_kth_value_r;
  assign out_short_set = out_short_set_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_count_r <= KW'(MAX_RANK))
    else $error("kept count above max rank");

  a_cmp_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> pos_r != '0)
    else $error("compare step at position zero");

  a_n_le_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_CMP || state_r == ST_OUT) |-> n_r <= k_r)
    else $error("fill exceeds rank during insertion");

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT) && kept_count_r == '0)
    else $error("result without a final read");

endmodule

### hw/rtl/streaming_kth_largest_select.sv
// Streaming k-th largest selector, top level: register port, rank clamp, sequencer.
// Depends on tkls_pkg, tkls_ctrl and tkls_store.
//
// Usage: a set of signed 32-bit samples enters on the in_ channel, one transfer
// per sample, in_last_of_set high on the final one. The block keeps the k largest
// samples in a sorted store and, after the final sample, sends one transfer on
// the out_ channel: the k-th largest value and short_set when the set held fewer
// than k samples (value is then the set minimum). The store then empties.
// k is register 0 (rank_k), written over the APB port while the block is idle;
// 0 acts as 1, values above MAX_RANK act as MAX_RANK.
// Each sample steps down the store past up to k kept values, one store read and one
// compare per kept value it reaches, paced by the single compare unit and the one
// read port of the store; in_stall is high in every state but idle, so a new sample
// is taken only once the last one is fully inserted. A final sample adds a result
// load step, which waits while a stalled result still holds the result register.
// Reset empties the store and the result register and sets k to 1.
// A stalled result stays in its register; non-final samples keep flowing, and a
// final sample waits at the result load until the register is free.
module streaming_kth_largest_select #(
  parameter int MAX_RANK = tkls_pkg::DEF_MAX_RANK
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tkls_pkg::CFG_AW-1:0]  paddr,
  input  logic [tkls_pkg::CFG_DW-1:0]  pwdata,
  output logic [tkls_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tkls_pkg::sample_t            in_sample_value,
  input  logic                         in_last_of_set,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tkls_pkg::sample_t            out_kth_value,
  output logic                         out_short_set
);
  import tkls_pkg::*;

  localparam int KW = $clog2(MAX_RANK + 1);
  localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  rank_t         rank_k_r, rank_k_nxt;
  logic [KW-1:0] eff_k;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = CFG_DW'(rank_k_r);

  always_comb begin
    rank_k_nxt = rank_k_r;
    if (cfg_wr && paddr == '0) begin
      rank_k_nxt = pwdata[RANK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_k_r <= rank_t'(1);
    end else begin
      rank_k_r <= rank_k_nxt;
    end
  end

  always_comb begin
    priority if (rank_k_r == '0) begin
      eff_k = KW'(1);
    end else if (32'(rank_k_r) > 32'(MAX_RANK)) begin
      eff_k = KW'(MAX_RANK);
    end else begin
      eff_k = KW'(rank_k_r);
    end
  end

  tkls_ctrl #(
    .MAX_RANK(MAX_RANK),
    .KW      (KW),
    .AW      (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .eff_k          (eff_k),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_value(in_sample_value),
    .in_last_of_set (in_last_of_set),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kth_value  (out_kth_value),
    .out_short_set  (out_short_set)
  );

endmodule

### bench/tb_streaming_kth_largest_select.sv
// self-checking bench for streaming_kth_largest_select: sets of signed samples with
// random gaps and result stalls, checked against an in-bench sorted-store predictor
// depends on tkls_pkg and the streaming_kth_largest_select rtl
module tb_streaming_kth_largest_select;
  timeunit 1ns;
  timeprecision 1ps;
  import tkls_pkg::*;

  localparam int MAX_RANK = DEF_MAX_RANK;
  localparam logic [CFG_AW-1:0] RANK_K_ADDR = '0;
  localparam int SETTLE_CYCLES = 3 * (3 + 2 * MAX_RANK) + 40;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_TAIL_ITEMS = 70;

  typedef struct {
    sample_t value;
    logic    last;
  } sample_item_t;

  typedef struct {
    sample_t value;
    logic    short_set;
  } kth_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t in_sample_value = '0;
  logic in_last_of_set = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t out_kth_value;
  logic out_short_set;

  sample_item_t pending_samples[$];
  kth_result_t expected_kth[$];
  sample_t kept_desc[MAX_RANK];
  int kept_n = 0;
  rank_t rank_setting = rank_t'(1);
  int mismatches = 0;
  int cycle_count = 0;
  int pushed_samples = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int in_gap_left = 0;
  int out_stall_left = 0;

  streaming_kth_largest_select #(.MAX_RANK(MAX_RANK)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample_value(in_sample_value),
    .in_last_of_set(in_last_of_set),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kth_value(out_kth_value),
    .out_short_set(out_short_set)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int effective_rank();
    if (rank_setting == 0) return 1;
    if (int'(rank_setting) > MAX_RANK) return MAX_RANK;
    return int'(rank_setting);
  endfunction

  // sorted insertion, largest first; equal values go after the kept ones
  function automatic void absorb_sample(sample_t v, logic last_flag);
    int k;
    int n;
    int pos;
    kth_result_t r;
    k = effective_rank();
    n = (kept_n > k) ? k : kept_n;
    pos = n;
    while (pos > 0 && kept_desc[pos-1] < v) begin
      if (pos < k) kept_desc[pos] = kept_desc[pos-1];
      pos--;
    end
    if (pos < k) kept_desc[pos] = v;
    if (n < k) n++;
    kept_n = n;
    if (last_flag) begin
      r.value = kept_desc[n-1];
      r.short_set = (n < k);
      expected_kth.push_back(r);
      kept_n = 0;
    end
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : sample_driver
    sample_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_sample(in_sample_value, in_last_of_set);
      if (!in_valid || !in_stall) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (in_idle_pct > 0 && $urandom_range(1, 100) <= in_idle_pct) begin
          in_gap_left = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          nxt = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_sample_value <= nxt.value;
          in_last_of_set <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    kth_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_kth.size() == 0) begin
          flag_mismatch($sformatf("result transfer with none expected, value %0d",
                                  out_kth_value));
        end else begin
          want = expected_kth.pop_front();
          if (out_kth_value !== want.value)
            flag_mismatch($sformatf("kth_value %0d, expected %0d", out_kth_value,
                                    want.value));
          if (out_short_set !== want.short_set)
            flag_mismatch($sformatf("short_set %b, expected %b", out_short_set,
                                    want.short_set));
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_stall <= 1'b1;
      end else if (out_stall_pct > 0 && $urandom_range(1, 100) <= out_stall_pct) begin
        out_stall_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_streaming_kth_largest_select: errors");
      $finish;
    end
  end

  task automatic push_sample(input sample_t v, input logic last_flag);
    sample_item_t it;
    it.value = v;
    it.last = last_flag;
    pending_samples.push_back(it);
    pushed_samples++;
  endtask

  // all transfers done, all results in, then let the store finish its last insert
  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_kth.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rank(input logic [CFG_DW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RANK_K_ADDR;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rank_setting = rank_t'(val[RANK_W-1:0]);
  endtask

  function automatic sample_t pick_value();
    case ($urandom_range(0, 9))
      0: return sample_t'(32'h8000_0000);
      1: return sample_t'(32'h7fff_ffff);
      2: return sample_t'(-$signed({31'd0, 1'($urandom_range(0, 1))}));
      3, 4, 5: return sample_t'($signed($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int phase_len, input bit leave_open);
    int n_in_phase;
    int set_len;
    int k;
    k = effective_rank();
    n_in_phase = 0;
    while (n_in_phase < phase_len) begin
      if ($urandom_range(0, 3) == 0) set_len = $urandom_range(1, k);
      else set_len = $urandom_range(k, k + 8);
      for (int j = 0; j < set_len; j++) push_sample(pick_value(), j == set_len - 1);
      n_in_phase += set_len;
    end
    if (leave_open) begin
      set_len = $urandom_range(1, k);
      for (int j = 0; j < set_len; j++) push_sample(pick_value(), 1'b0);
    end
  endtask

  initial begin : stimulus
    int phase_idx;
    int random_start;
    int pct_choice[4];
    pct_choice = '{0, 5, 25, 50};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset rank selects the maximum, extremes of the value range
    push_sample(sample_t'(32'h8000_0000), 1'b0);
    push_sample(sample_t'(32'h7fff_ffff), 1'b0);
    push_sample(sample_t'(0), 1'b1);
    push_sample(sample_t'(-1), 1'b1);
    wait_drained();
    // duplicates and a short set, upper data bits ignored
    write_rank({25'h1abcde, 7'd3});
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(7), 1'b0);
    push_sample(sample_t'(5), 1'b1);
    push_sample(sample_t'(10), 1'b0);
    push_sample(sample_t'(-3), 1'b1);
    wait_drained();
    // rank zero behaves as one
    write_rank(32'd0);
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(9), 1'b1);
    wait_drained();
    // rank above max clamps
    write_rank(32'd127);
    push_sample(sample_t'(-20), 1'b0);
    push_sample(sample_t'(40), 1'b1);
    wait_drained();
    // rank shrinks mid-set
    write_rank(32'd4);
    for (int v = 1; v <= 4; v++) push_sample(sample_t'(v), 1'b0);
    wait_drained();
    write_rank(32'd2);
    push_sample(sample_t'(0), 1'b1);
    push_sample(sample_t'(10), 1'b0);
    push_sample(sample_t'(20), 1'b0);
    push_sample(sample_t'(30), 1'b0);
    wait_drained();
    // rank grows mid-set, dropped values stay lost
    write_rank(32'd5);
    push_sample(sample_t'(40), 1'b1);

    random_start = pushed_samples;
    phase_idx = 0;
    while (pushed_samples - random_start < RANDOM_ITEMS - QUIET_TAIL_ITEMS) begin
      wait_drained();
      case (phase_idx)
        0: write_rank(32'd64);
        1: write_rank(32'd0);
        2: write_rank(32'd127);
        3: write_rank(32'd1);
        default: begin
          case ($urandom_range(0, 9))
            0: write_rank(32'd64);
            1: write_rank(32'($urandom_range(65, 127)));
            2: write_rank(32'd0);
            3: write_rank(32'd1);
            4: write_rank(32'($urandom_range(11, 63)));
            default: write_rank(32'($urandom_range(2, 10)));
          endcase
        end
      endcase
      in_idle_pct = pct_choice[$urandom_range(0, 3)];
      out_stall_pct = pct_choice[$urandom_range(0, 3)];
      run_phase($urandom_range(40, 90), $urandom_range(0, 4) == 0);
      phase_idx++;
    end

    wait_drained();
    write_rank(32'($urandom_range(2, 8)));
    in_idle_pct = 0;
    out_stall_pct = 0;
    run_phase(QUIET_TAIL_ITEMS, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_streaming_kth_largest_select: clean");
    end else begin
      $display("tb_streaming_kth_largest_select: errors");
    end
    $finish;
  end

endmodule
